// ===== src/hlsu_pkg.sv =====
// Package for the HMM segment length score unit: field widths, codes, table entry type
// and the natural log and log-factorial ROM contents that are built at elaboration.
// Used by hmm_length_score_unit, by its checker and by the testbench; it depends on nothing else.
package hlsu_pkg;

    // Sizes of the design.
    localparam int MAX_LENGTH = 4096;
    localparam int NUM_STATES = 1024;
    localparam int FRAC_BITS  = 16;

    // Field widths.
    localparam int LEN_W      = 13;
    localparam int STATE_W    = 10;
    localparam int LAMBDA_W   = 29;
    localparam int ROUND_W    = 13;
    localparam int LOG_W      = 32;
    localparam int RESCALE_W  = 48;
    localparam int SCORE_W    = 48;
    localparam int HIMS_W     = 41;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 41;

    // ROM and table geometry.
    localparam int LN_W      = 32;
    localparam int LF_W      = 48;
    localparam int ROM_AW    = $clog2(MAX_LENGTH + 1);
    localparam int TAB_AW    = $clog2(NUM_STATES);
    localparam int ROM_CHUNK = 1024;

    // Gaussian product: factor times half_inv_mean_sq, then a rounding shift.
    localparam int F_W      = 2 * LEN_W;
    localparam int G_PROD_W = F_W + HIMS_W;
    localparam int G_SHIFT  = 40 - FRAC_BITS;
    localparam int WIDE_W   = 52;

    // Model codes.
    typedef enum logic [2:0] {
        MODEL_NONE         = 3'd0,
        MODEL_POISSON      = 3'd1,
        MODEL_THRESHOLD    = 3'd2,
        MODEL_LINEAR_DECAY = 3'd3,
        MODEL_GAUSSIAN     = 3'd4
    } t_model_e;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODEL_TYPE       = 3'd0,
        CFG_IS_FRAMEWISE     = 3'd1,
        CFG_LENGTH_THRESHOLD = 3'd2,
        CFG_LOG_EPSILON      = 3'd3,
        CFG_HALF_INV_MEAN_SQ = 3'd4
    } t_cfg_idx_e;

    // Request codes.
    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req_e;

    // How the last stage forms the score.
    typedef enum logic [1:0] {
        KIND_SIMPLE      = 2'd0,
        KIND_POISSON_SEG = 2'd1,
        KIND_GAUSS       = 2'd2
    } t_kind_e;

    // One per-state table entry.
    typedef struct packed {
        logic        [LAMBDA_W-1:0]  lam;
        logic        [ROUND_W-1:0]   lr;
        logic signed [LOG_W-1:0]     ll;
        logic signed [RESCALE_W-1:0] rs;
    } t_tab_entry;

    typedef logic [LN_W-1:0] t_ln_rom [0:MAX_LENGTH];
    typedef logic [LF_W-1:0] t_lf_rom [0:MAX_LENGTH];

    // Shift-and-subtract division, used only while building the ROMs.
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(k) in Q.FRAC_BITS: ln(k/(k-1)) = 2*atanh(1/(2k-1)) summed in Q.60, then rounded.
    function automatic t_ln_rom f_build_ln();
        t_ln_rom     rom;
        logic [63:0] acc;
        logic [63:0] d;
        logic [63:0] d2;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] sum;
        logic [63:0] rnd;
        int          k;
        acc = '0;
        for (int c = 0; c <= MAX_LENGTH / ROM_CHUNK; c++) begin
            for (int j = 0; j < ROM_CHUNK; j++) begin
                k = c * ROM_CHUNK + j;
                if (k <= MAX_LENGTH) begin
                    if (k < 2) begin
                        rom[k[ROM_AW-1:0]] = '0;
                    end else begin
                        d   = 64'(2 * k - 1);
                        d2  = d * d;
                        t   = f_udiv(64'd1 << 61, d);
                        n   = 64'd1;
                        sum = '0;
                        while (t != 64'd0) begin
                            sum = sum + f_udiv(t, n);
                            t   = f_udiv(t, d2);
                            n   = n + 64'd2;
                        end
                        acc = acc + sum;
                        rnd = (acc + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
                        rom[k[ROM_AW-1:0]] = rnd[LN_W-1:0];
                    end
                end
            end
        end
        return rom;
    endfunction

    // Log-factorial as prefix sums of the log table.
    function automatic t_lf_rom f_build_lf(input t_ln_rom ln);
        t_lf_rom rom;
        int      k;
        for (int c = 0; c <= MAX_LENGTH / ROM_CHUNK; c++) begin
            for (int j = 0; j < ROM_CHUNK; j++) begin
                k = c * ROM_CHUNK + j;
                if (k <= MAX_LENGTH) begin
                    if (k < 2) begin
                        rom[k[ROM_AW-1:0]] = '0;
                    end else begin
                        rom[k[ROM_AW-1:0]] = rom[(k - 1) % (MAX_LENGTH + 1)]
                                           + LF_W'(ln[k[ROM_AW-1:0]]);
                    end
                end
            end
        end
        return rom;
    endfunction

    localparam t_ln_rom LN_ROM = f_build_ln();
    localparam t_lf_rom LF_ROM = f_build_lf(LN_ROM);

    // Clamp a length-like value to the last ROM entry.
    function automatic logic [ROM_AW-1:0] f_rom_idx(input logic [LEN_W+1:0] v);
        logic [ROM_AW-1:0] r;
        if (int'(v) > MAX_LENGTH) begin
            r = ROM_AW'(MAX_LENGTH);
        end else begin
            r = v[ROM_AW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/hmm_length_score_unit.sv =====
// HMM segment length score unit: four-stage pipeline with the per-state table memory.
// Depends on hlsu_pkg for widths, codes, the table entry type and the ROM contents.

// A new load or query word can be accepted every clock while the output is not stalled.
// A word enters the first register stage at its accepting edge and passes through the stage
// 2 and stage 3 registers into the output register. The four register stages hold the
// table memory and ROM reads, the first multiply and differences, the gaussian partial
// products and the final add with saturation. A load word writes its state entry at
// acceptance, so a query in the very next cycle already sees it.
// Scores are signed Q.16 and saturate to 48 bits; a load gives a word with score_valid low.
// Configuration is taken in any cycle and must only be written while the unit is idle.
module hmm_length_score_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write channel.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [hlsu_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [hlsu_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Request channel.
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_req_type,
    input  logic [hlsu_pkg::STATE_W-1:0]          i_state_index,
    input  logic [hlsu_pkg::LEN_W-1:0]            i_seg_length,
    input  logic [hlsu_pkg::LAMBDA_W-1:0]         i_lambda_fixed,
    input  logic [hlsu_pkg::ROUND_W-1:0]          i_lambda_rounded,
    input  logic signed [hlsu_pkg::LOG_W-1:0]     i_log_lambda,
    input  logic signed [hlsu_pkg::RESCALE_W-1:0] i_rescale_value,
    // Result channel.
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [hlsu_pkg::SCORE_W-1:0]   o_frame_score,
    output logic signed [hlsu_pkg::SCORE_W-1:0]   o_segment_score,
    output logic                                  o_score_valid
);

    localparam int LEN_W    = hlsu_pkg::LEN_W;
    localparam int LOG_W    = hlsu_pkg::LOG_W;
    localparam int WIDE_W   = hlsu_pkg::WIDE_W;
    localparam int SCORE_W  = hlsu_pkg::SCORE_W;
    localparam int F_W      = hlsu_pkg::F_W;
    localparam int G_PROD_W = hlsu_pkg::G_PROD_W;
    localparam int HI_W     = hlsu_pkg::HIMS_W - 32;
    localparam int PROD_W   = LEN_W + 1 + LOG_W;
    localparam int PS_W     = 51;
    localparam logic [G_PROD_W-1:0] G_ROUND = G_PROD_W'(1) << (hlsu_pkg::G_SHIFT - 1);
    localparam logic [G_PROD_W-1:0] G_CAP   = G_PROD_W'(1) << (SCORE_W - 1);
    localparam logic signed [WIDE_W-1:0] SAT_HI =
        {{(WIDE_W-SCORE_W+1){1'b0}}, {(SCORE_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_LO =
        {{(WIDE_W-SCORE_W+1){1'b1}}, {(SCORE_W-1){1'b0}}};

    // Configuration registers.
    logic [2:0]                        r_model_type;
    logic                              r_is_framewise;
    logic [LEN_W-1:0]                  r_length_threshold;
    logic signed [LOG_W-1:0]           r_log_epsilon;
    logic [hlsu_pkg::HIMS_W-1:0]       r_half_inv_mean_sq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_type       <= hlsu_pkg::MODEL_NONE;
            r_is_framewise     <= 1'b1;
            r_length_threshold <= LEN_W'(100);
            r_log_epsilon      <= -32'sd452701;
            r_half_inv_mean_sq <= 41'd54975581;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hlsu_pkg::CFG_MODEL_TYPE:       r_model_type       <= i_cfg_data[2:0];
                hlsu_pkg::CFG_IS_FRAMEWISE:     r_is_framewise     <= i_cfg_data[0];
                hlsu_pkg::CFG_LENGTH_THRESHOLD: r_length_threshold <= i_cfg_data[LEN_W-1:0];
                hlsu_pkg::CFG_LOG_EPSILON:      r_log_epsilon      <= i_cfg_data[LOG_W-1:0];
                hlsu_pkg::CFG_HALF_INV_MEAN_SQ: r_half_inv_mean_sq <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its word moves on.
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic en1, en2, en3, en4, in_acc;

    assign en4    = !r_s4_v || i_ready;
    assign en3    = !r_s3_v || en4;
    assign en2    = !r_s2_v || en3;
    assign en1    = !r_s1_v || en2;
    assign o_ready = en1;
    assign in_acc = i_valid && en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_v <= i_valid;
            end
            if (en2) begin
                r_s2_v <= r_s1_v;
            end
            if (en3) begin
                r_s3_v <= r_s2_v;
            end
            if (en4) begin
                r_s4_v <= r_s3_v;
            end
        end
    end

    // Acceptance: lengths, threshold compares, ROM addresses and the length square.
    logic [LEN_W+1:0]           two_t, a_full, a_plus1, len_x, thr_x;
    logic                       le_t, gt_2t, a_zero, st_ok;
    logic [hlsu_pkg::ROM_AW-1:0] addr_a, addr_b, addr_f;
    logic [F_W-1:0]             len_sq, fact;
    logic [LEN_W:0]             f_frame;
    logic [hlsu_pkg::TAB_AW-1:0] tab_addr;
    hlsu_pkg::t_tab_entry       wr_entry;

    always_comb begin
        len_x   = {2'b00, i_seg_length};
        thr_x   = {2'b00, r_length_threshold};
        two_t   = {1'b0, r_length_threshold, 1'b0};
        a_full  = two_t - len_x;
        a_plus1 = a_full + 1'b1;
        le_t    = i_seg_length <= r_length_threshold;
        gt_2t   = len_x > two_t;
        a_zero  = a_full == '0;
        st_ok   = int'(i_state_index) < hlsu_pkg::NUM_STATES;
        if (r_model_type == hlsu_pkg::MODEL_POISSON) begin
            addr_a = hlsu_pkg::f_rom_idx(len_x);
        end else begin
            addr_a = hlsu_pkg::f_rom_idx(a_full);
        end
        if (r_is_framewise) begin
            addr_b = hlsu_pkg::f_rom_idx(a_plus1);
        end else begin
            addr_b = hlsu_pkg::f_rom_idx(thr_x);
        end
        addr_f = hlsu_pkg::f_rom_idx(len_x);
        len_sq = {{LEN_W{1'b0}}, i_seg_length} * {{LEN_W{1'b0}}, i_seg_length};
        if (i_seg_length == '0) begin
            f_frame = '0;
        end else begin
            f_frame = {i_seg_length, 1'b0} - 1'b1;
        end
        fact     = r_is_framewise ? F_W'(f_frame) : len_sq;
        tab_addr = i_state_index[hlsu_pkg::TAB_AW-1:0];
        wr_entry = '{lam: i_lambda_fixed, lr: i_lambda_rounded,
                     ll: i_log_lambda, rs: i_rescale_value};
    end

    // Per-state table memory.
    hlsu_pkg::t_tab_entry tab_mem [0:hlsu_pkg::NUM_STATES-1];
    hlsu_pkg::t_tab_entry r_s1_tab;

    always_ff @(posedge i_clk) begin
        if (in_acc && i_req_type == hlsu_pkg::REQ_LOAD && st_ok) begin
            tab_mem[tab_addr] <= wr_entry;
        end
        if (en1) begin
            r_s1_tab <= tab_mem[tab_addr];
        end
    end

    // Stage 1 registers, with ROM reads.
    logic                        r_s1_query, r_s1_frame, r_s1_le_t, r_s1_gt_2t;
    logic                        r_s1_a_zero, r_s1_st_ok;
    logic [2:0]                  r_s1_model;
    logic [LEN_W-1:0]            r_s1_len, r_s1_thr;
    logic [F_W-1:0]              r_s1_fact;
    logic [hlsu_pkg::LN_W-1:0]   r_s1_ln_a, r_s1_ln_b;
    logic [hlsu_pkg::LF_W-1:0]   r_s1_lf;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_query  <= i_req_type == hlsu_pkg::REQ_QUERY;
            r_s1_frame  <= r_is_framewise;
            r_s1_model  <= r_model_type;
            r_s1_len    <= i_seg_length;
            r_s1_thr    <= r_length_threshold;
            r_s1_le_t   <= le_t;
            r_s1_gt_2t  <= gt_2t;
            r_s1_a_zero <= a_zero;
            r_s1_st_ok  <= st_ok;
            r_s1_fact   <= fact;
            r_s1_ln_a   <= hlsu_pkg::LN_ROM[addr_a];
            r_s1_ln_b   <= hlsu_pkg::LN_ROM[addr_b];
            r_s1_lf     <= hlsu_pkg::LF_ROM[addr_f];
        end
    end

    // Stage 2: gate the table entry, log differences and the length multiply.
    hlsu_pkg::t_tab_entry       tab;
    logic signed [LOG_W:0]      pf, diff;
    logic signed [LEN_W:0]      mx;
    logic signed [LOG_W-1:0]    my;
    logic signed [PROD_W-1:0]   prod;

    always_comb begin
        tab = r_s1_st_ok ? r_s1_tab : '0;
        if (r_s1_len <= tab.lr) begin
            pf = '0;
        end else begin
            pf = $signed({tab.ll[LOG_W-1], tab.ll}) - $signed({1'b0, r_s1_ln_a});
        end
        diff = $signed({1'b0, r_s1_ln_a}) - $signed({1'b0, r_s1_ln_b});
        if (r_s1_model == hlsu_pkg::MODEL_POISSON) begin
            mx = $signed({1'b0, r_s1_len});
            my = tab.ll;
        end else begin
            mx = $signed({1'b0, r_s1_len}) - $signed({1'b0, r_s1_thr});
            my = r_log_epsilon;
        end
        prod = mx * my;
    end

    logic                          r_s2_query, r_s2_frame, r_s2_le_t, r_s2_gt_2t, r_s2_a_zero;
    logic [2:0]                    r_s2_model;
    logic [F_W-1:0]                r_s2_fact;
    logic signed [PROD_W-1:0]      r_s2_prod;
    logic signed [LOG_W:0]         r_s2_pf, r_s2_diff;
    logic [hlsu_pkg::LAMBDA_W-1:0] r_s2_lam;
    logic [hlsu_pkg::LF_W-1:0]     r_s2_lf;
    logic signed [hlsu_pkg::RESCALE_W-1:0] r_s2_rs;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_query  <= r_s1_query;
            r_s2_frame  <= r_s1_frame;
            r_s2_model  <= r_s1_model;
            r_s2_le_t   <= r_s1_le_t;
            r_s2_gt_2t  <= r_s1_gt_2t;
            r_s2_a_zero <= r_s1_a_zero;
            r_s2_fact   <= r_s1_fact;
            r_s2_prod   <= prod;
            r_s2_pf     <= pf;
            r_s2_diff   <= diff;
            r_s2_lam    <= tab.lam;
            r_s2_lf     <= r_s1_lf;
            r_s2_rs     <= tab.rs;
        end
    end

    // Stage 3: gaussian partial products, poisson segment partial sum, simple scores.
    logic [F_W+31:0]            pp_lo;
    logic [F_W+HI_W-1:0]        pp_hi;
    logic signed [PS_W-1:0]     ps;
    logic signed [PROD_W-1:0]   sv, eps_x, diff_x;
    hlsu_pkg::t_kind_e          kind;

    always_comb begin
        pp_lo  = {32'b0, r_s2_fact} * {{F_W{1'b0}}, r_half_inv_mean_sq[31:0]};
        pp_hi  = {{HI_W{1'b0}}, r_s2_fact}
               * {{F_W{1'b0}}, r_half_inv_mean_sq[hlsu_pkg::HIMS_W-1:32]};
        ps     = PS_W'(r_s2_prod) - $signed({22'b0, r_s2_lam}) - $signed({3'b0, r_s2_lf});
        eps_x  = PROD_W'(r_log_epsilon);
        diff_x = PROD_W'(r_s2_diff);
        sv     = '0;
        kind   = hlsu_pkg::KIND_SIMPLE;
        case (r_s2_model)
            hlsu_pkg::MODEL_POISSON: begin
                sv = PROD_W'(r_s2_pf);
                if (!r_s2_frame) begin
                    kind = hlsu_pkg::KIND_POISSON_SEG;
                end
            end
            hlsu_pkg::MODEL_THRESHOLD: begin
                if (!r_s2_le_t) begin
                    sv = r_s2_frame ? eps_x : r_s2_prod;
                end
            end
            hlsu_pkg::MODEL_LINEAR_DECAY: begin
                // A zero distance to twice the threshold is minus infinity, so epsilon.
                if (r_s2_le_t) begin
                    sv = '0;
                end else if (r_s2_gt_2t || r_s2_a_zero || diff_x < eps_x) begin
                    sv = eps_x;
                end else begin
                    sv = diff_x;
                end
            end
            hlsu_pkg::MODEL_GAUSSIAN: begin
                kind = hlsu_pkg::KIND_GAUSS;
            end
            default: ;
        endcase
    end

    logic                        r_s3_query, r_s3_frame;
    hlsu_pkg::t_kind_e           r_s3_kind;
    logic [F_W+31:0]             r_s3_pp_lo;
    logic [F_W+HI_W-1:0]         r_s3_pp_hi;
    logic signed [PS_W-1:0]      r_s3_ps;
    logic signed [hlsu_pkg::RESCALE_W-1:0] r_s3_rs;
    logic signed [PROD_W-1:0]    r_s3_sv;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_query <= r_s2_query;
            r_s3_frame <= r_s2_frame;
            r_s3_kind  <= kind;
            r_s3_pp_lo <= pp_lo;
            r_s3_pp_hi <= pp_hi;
            r_s3_ps    <= ps;
            r_s3_rs    <= r_s2_rs;
            r_s3_sv    <= sv;
        end
    end

    // Stage 4: gaussian sum with rounding, rescale subtract, saturation and routing.
    logic [G_PROD_W-1:0]        g_full, g_mag;
    logic signed [WIDE_W-1:0]   wide;
    logic signed [SCORE_W-1:0]  score;

    always_comb begin
        g_full = {r_s3_pp_hi, 32'b0} + G_PROD_W'(r_s3_pp_lo) + G_ROUND;
        g_mag  = g_full >> hlsu_pkg::G_SHIFT;
        if (g_mag > G_CAP) begin
            g_mag = G_CAP;
        end
        case (r_s3_kind)
            hlsu_pkg::KIND_GAUSS:       wide = -$signed(g_mag[WIDE_W-1:0]);
            hlsu_pkg::KIND_POISSON_SEG: wide = WIDE_W'(r_s3_ps) - WIDE_W'(r_s3_rs);
            default:                    wide = WIDE_W'(r_s3_sv);
        endcase
        if (wide > SAT_HI) begin
            score = SAT_HI[SCORE_W-1:0];
        end else if (wide < SAT_LO) begin
            score = SAT_LO[SCORE_W-1:0];
        end else begin
            score = wide[SCORE_W-1:0];
        end
    end

    logic signed [SCORE_W-1:0] r_s4_frame, r_s4_seg;
    logic                      r_s4_score_valid;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_frame       <= (r_s3_query && r_s3_frame) ? score : '0;
            r_s4_seg         <= (r_s3_query && !r_s3_frame) ? score : '0;
            r_s4_score_valid <= r_s3_query;
        end
    end

    assign o_valid         = r_s4_v;
    assign o_frame_score   = r_s4_frame;
    assign o_segment_score = r_s4_seg;
    assign o_score_valid   = r_s4_score_valid;

endmodule

// ===== src/hlsu_checker.sv =====
// Port-level checker for the HMM segment length score unit, bound to its top level.
// Depends on hlsu_pkg for field widths and on the ports of hmm_length_score_unit.
module hlsu_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_cfg_valid,
    input logic                                  o_cfg_ready,
    input logic [hlsu_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input logic [hlsu_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input logic                                  i_valid,
    input logic                                  o_ready,
    input logic                                  i_req_type,
    input logic [hlsu_pkg::STATE_W-1:0]          i_state_index,
    input logic [hlsu_pkg::LEN_W-1:0]            i_seg_length,
    input logic [hlsu_pkg::LAMBDA_W-1:0]         i_lambda_fixed,
    input logic [hlsu_pkg::ROUND_W-1:0]          i_lambda_rounded,
    input logic signed [hlsu_pkg::LOG_W-1:0]     i_log_lambda,
    input logic signed [hlsu_pkg::RESCALE_W-1:0] i_rescale_value,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic signed [hlsu_pkg::SCORE_W-1:0]   o_frame_score,
    input logic signed [hlsu_pkg::SCORE_W-1:0]   o_segment_score,
    input logic                                  o_score_valid
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_score)
                                && $stable(o_segment_score) && $stable(o_score_valid))
        else $error("result word changed while stalled");

    // A load acknowledge carries zero scores.
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_score_valid |-> o_frame_score == '0 && o_segment_score == '0)
        else $error("load acknowledge with nonzero score");

    // A score shows in at most one of the two fields.
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_score_valid |-> o_frame_score == '0 || o_segment_score == '0)
        else $error("score in both fields");

    // The request side only blocks when the full pipeline backs up behind the output.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("request side blocked without an output stall");

    // No result word right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_valid)
        else $error("result word valid right after reset");

endmodule

bind hmm_length_score_unit hlsu_checker u_hlsu_checker (.*);

// ===== dv/hmm_length_score_unit_tb.sv =====
// Self-checking testbench for hmm_length_score_unit: random load and query words, random idling
// on both sides, and a score predictor with its own log and log-factorial tables.
// Depends on hlsu_pkg for widths, model codes, request codes and register indexes.
module hmm_length_score_unit_tb;

    typedef struct {
        hlsu_pkg::t_req_e                       req;
        logic [hlsu_pkg::STATE_W-1:0]           st;
        logic [hlsu_pkg::LEN_W-1:0]             len;
        logic [hlsu_pkg::LAMBDA_W-1:0]          lam;
        logic [hlsu_pkg::ROUND_W-1:0]           lr;
        logic signed [hlsu_pkg::LOG_W-1:0]      ll;
        logic signed [hlsu_pkg::RESCALE_W-1:0]  rs;
    } t_word;

    typedef struct {
        logic [hlsu_pkg::SCORE_W-1:0] frame;
        logic [hlsu_pkg::SCORE_W-1:0] seg;
        logic                         sv;
    } t_score;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [hlsu_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [hlsu_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_req_type = 1'b0;
    logic [hlsu_pkg::STATE_W-1:0] i_state_index = '0;
    logic [hlsu_pkg::LEN_W-1:0] i_seg_length = '0;
    logic [hlsu_pkg::LAMBDA_W-1:0] i_lambda_fixed = '0;
    logic [hlsu_pkg::ROUND_W-1:0] i_lambda_rounded = '0;
    logic signed [hlsu_pkg::LOG_W-1:0] i_log_lambda = '0;
    logic signed [hlsu_pkg::RESCALE_W-1:0] i_rescale_value = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [hlsu_pkg::SCORE_W-1:0] o_frame_score;
    logic signed [hlsu_pkg::SCORE_W-1:0] o_segment_score;
    logic o_score_valid;

    hmm_length_score_unit dut (.*);

    // Word queues, predicted scores and the predictor's copy of the unit.
    t_word  pending_words[$];
    t_score expected_scores[$];
    t_word  cur_word;
    int     errors = 0;
    int     drv_wait = 0;
    int     mon_wait = 0;
    bit     drv_quiet = 1'b0;
    bit     mon_quiet = 1'b0;

    longint ln_tab [0:hlsu_pkg::MAX_LENGTH];
    longint lf_tab [0:hlsu_pkg::MAX_LENGTH];
    logic [hlsu_pkg::LAMBDA_W-1:0]         lam_mem [0:hlsu_pkg::NUM_STATES-1];
    logic [hlsu_pkg::ROUND_W-1:0]          lr_mem  [0:hlsu_pkg::NUM_STATES-1];
    logic signed [hlsu_pkg::LOG_W-1:0]     ll_mem  [0:hlsu_pkg::NUM_STATES-1];
    logic signed [hlsu_pkg::RESCALE_W-1:0] rs_mem  [0:hlsu_pkg::NUM_STATES-1];
    logic [hlsu_pkg::STATE_W-1:0]          loaded_states[$];

    logic [2:0]                  cfg_model = hlsu_pkg::MODEL_NONE;
    logic                        cfg_fw = 1'b1;
    longint                      cfg_thr = 100;
    longint                      cfg_eps = -452701;
    logic [hlsu_pkg::HIMS_W-1:0] cfg_hims = 41'd54975581;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("hmm_length_score_unit_tb: errors");
        $finish;
    end

    // Log and log-factorial tables by summing ln(k/(k-1)) = 2*atanh(1/(2k-1)) in Q.60.
    function automatic void build_log_tables();
        longint unsigned acc, d, t, n, sum;
        acc = 0;
        ln_tab[0] = 0; ln_tab[1] = 0; lf_tab[0] = 0; lf_tab[1] = 0;
        for (int k = 2; k <= hlsu_pkg::MAX_LENGTH; k++) begin
            d = 2 * k - 1;
            t = (64'd1 << 61) / d;
            n = 1;
            sum = 0;
            while (t != 0) begin
                sum += t / n;
                t /= d * d;
                n += 2;
            end
            acc += sum;
            ln_tab[k] = longint'((acc + (64'd1 << (59 - hlsu_pkg::FRAC_BITS)))
                                 >> (60 - hlsu_pkg::FRAC_BITS));
            lf_tab[k] = lf_tab[k-1] + ln_tab[k];
        end
    endfunction

    function automatic longint ln_at(longint k);
        return ln_tab[k > hlsu_pkg::MAX_LENGTH ? hlsu_pkg::MAX_LENGTH : k];
    endfunction

    // Raw score of one query before saturation.
    function automatic longint raw_score(t_word w);
        longint L, T, a, v;
        logic [127:0] prod;
        logic [127:0] mag;
        L = w.len;
        T = cfg_thr;
        case (cfg_model)
            hlsu_pkg::MODEL_POISSON: begin
                if (cfg_fw) return (L <= lr_mem[w.st]) ? 0 : ll_mem[w.st] - ln_at(L);
                return L * ll_mem[w.st] - longint'(lam_mem[w.st])
                       - lf_tab[L > hlsu_pkg::MAX_LENGTH ? hlsu_pkg::MAX_LENGTH : L]
                       - rs_mem[w.st];
            end
            hlsu_pkg::MODEL_THRESHOLD: begin
                if (L <= T) return 0;
                return cfg_fw ? cfg_eps : (L - T) * cfg_eps;
            end
            hlsu_pkg::MODEL_LINEAR_DECAY: begin
                if (L <= T) return 0;
                if (L > 2 * T) return cfg_eps;
                a = 2 * T - L;
                // The log of zero is minus infinity, which clamps to log epsilon.
                if (a == 0) return cfg_eps;
                v = cfg_fw ? ln_at(a) - ln_at(a + 1) : ln_at(a) - ln_at(T);
                return v < cfg_eps ? cfg_eps : v;
            end
            hlsu_pkg::MODEL_GAUSSIAN: begin
                prod = cfg_fw ? ((L == 0) ? 128'd0 : 128'(2 * L - 1)) : 128'(L * L);
                prod = prod * cfg_hims;
                mag = (prod + (128'd1 << (hlsu_pkg::G_SHIFT - 1))) >> hlsu_pkg::G_SHIFT;
                if (mag > (128'd1 << 47)) mag = 128'd1 << 47;
                return -longint'(mag[63:0]);
            end
            default: return 0;
        endcase
    endfunction

    // Expected result word; a load also updates the predictor's table.
    function automatic t_score predict_score(t_word w);
        t_score r;
        longint s;
        r = '{default: '0};
        if (w.req == hlsu_pkg::REQ_LOAD) begin
            lam_mem[w.st] = w.lam;
            lr_mem[w.st] = w.lr;
            ll_mem[w.st] = w.ll;
            rs_mem[w.st] = w.rs;
            return r;
        end
        s = raw_score(w);
        if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
        if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
        if (cfg_fw) r.frame = s[hlsu_pkg::SCORE_W-1:0];
        else r.seg = s[hlsu_pkg::SCORE_W-1:0];
        r.sv = 1'b1;
        return r;
    endfunction

    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 15) == 0) quiet = ~quiet;
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic report_mismatch(string field, logic [hlsu_pkg::SCORE_W-1:0] got,
                                   logic [hlsu_pkg::SCORE_W-1:0] want);
        $display("mismatch on %s: got %h, expected %h", field, got, want);
        errors++;
    endtask

    // Driver: presents the next pending word after a random gap.
    always @(posedge i_clk) begin : driver
        logic fire;
        fire = i_valid && o_ready;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (fire) begin
                expected_scores.push_back(predict_score(cur_word));
                drv_wait = draw_wait(drv_quiet);
            end
            if (!i_valid || fire) begin
                if (drv_wait > 0) begin
                    drv_wait--;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    cur_word = pending_words.pop_front();
                    i_req_type <= cur_word.req;
                    i_state_index <= cur_word.st;
                    i_seg_length <= cur_word.len;
                    i_lambda_fixed <= cur_word.lam;
                    i_lambda_rounded <= cur_word.lr;
                    i_log_lambda <= cur_word.ll;
                    i_rescale_value <= cur_word.rs;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_score want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_scores.size() == 0) begin
                    $display("result word with no prediction waiting");
                    errors++;
                end else begin
                    want = expected_scores.pop_front();
                    if (o_frame_score !== want.frame)
                        report_mismatch("frame_score", o_frame_score, want.frame);
                    if (o_segment_score !== want.seg)
                        report_mismatch("segment_score", o_segment_score, want.seg);
                    if (o_score_valid !== want.sv)
                        report_mismatch("score_valid", 48'(o_score_valid), 48'(want.sv));
                end
                mon_wait = draw_wait(mon_quiet);
            end
            if (mon_wait > 0) begin
                mon_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(hlsu_pkg::t_cfg_idx_e idx, logic [hlsu_pkg::CFG_DATA_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            hlsu_pkg::CFG_MODEL_TYPE:       cfg_model = val[2:0];
            hlsu_pkg::CFG_IS_FRAMEWISE:     cfg_fw = val[0];
            hlsu_pkg::CFG_LENGTH_THRESHOLD: cfg_thr = val[hlsu_pkg::LEN_W-1:0];
            hlsu_pkg::CFG_LOG_EPSILON:
                cfg_eps = longint'($signed(val[hlsu_pkg::LOG_W-1:0]));
            default:                        cfg_hims = val[hlsu_pkg::HIMS_W-1:0];
        endcase
        @(posedge i_clk);
    endtask

    // Idle is judged at the falling edge, once the driver's updates have settled.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_words.size() > 0 || i_valid || expected_scores.size() > 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic add_load(logic [hlsu_pkg::STATE_W-1:0] st,
                            logic [hlsu_pkg::LAMBDA_W-1:0] lam,
                            logic [hlsu_pkg::ROUND_W-1:0] lr, logic [hlsu_pkg::LOG_W-1:0] ll,
                            logic [hlsu_pkg::RESCALE_W-1:0] rs);
        t_word w;
        w = '{hlsu_pkg::REQ_LOAD, st, hlsu_pkg::LEN_W'($urandom), lam, lr, ll, rs};
        pending_words.push_back(w);
        loaded_states.push_back(st);
    endtask

    task automatic add_query(logic [hlsu_pkg::LEN_W-1:0] len);
        t_word w;
        w = '{hlsu_pkg::REQ_QUERY, loaded_states[$urandom_range(0, loaded_states.size() - 1)],
              len, hlsu_pkg::LAMBDA_W'($urandom), hlsu_pkg::ROUND_W'($urandom), $urandom,
              hlsu_pkg::RESCALE_W'({$urandom, $urandom})};
        pending_words.push_back(w);
    endtask

    // Lengths cluster around the threshold, twice the threshold and the ends of the range.
    function automatic longint pick_length();
        longint v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, hlsu_pkg::MAX_LENGTH);
            1: v = cfg_thr + $signed($urandom_range(0, 4)) - 2;
            2: v = 2 * cfg_thr + $signed($urandom_range(0, 4)) - 2;
            3: v = ($urandom_range(0, 2) == 0) ? 0 :
                   (($urandom_range(0, 1) == 0) ? 1 : hlsu_pkg::MAX_LENGTH);
            4: v = $urandom_range(0, 64);
            default: v = $urandom_range(0, 300);
        endcase
        if (v < 0) v = 0;
        if (v > hlsu_pkg::MAX_LENGTH) v = hlsu_pkg::MAX_LENGTH;
        return v;
    endfunction

    initial begin
        logic [hlsu_pkg::CFG_DATA_W-1:0] v;
        build_log_tables();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Loads with extreme table values, then the edge lengths under reset settings.
        add_load(10'd0, 29'h1000_0000, 13'd4096, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
        add_load(10'd1023, 29'd0, 13'd0, 32'h8000_0000, 48'h8000_0000_0000);
        add_load(10'd512, 29'd0, 13'd0, 32'd0, 48'd0);
        add_load(10'd300, 29'd6553600, 13'd100, 32'd301804, 48'd0);
        foreach (loaded_states[i]) begin
            add_query(13'd0);
            add_query(13'd4096);
        end
        add_query(13'd1);
        add_query(13'd100);
        add_query(13'd101);

        for (int p = 0; p <= 14; p++) begin
            if (p > 0) begin
                wait_idle();
                v = hlsu_pkg::CFG_DATA_W'((p <= 10) ? p % 5 : $urandom_range(0, 4));
                write_reg(hlsu_pkg::CFG_MODEL_TYPE, v);
                v = hlsu_pkg::CFG_DATA_W'((p <= 10) ? (p / 5) % 2 : $urandom_range(0, 1));
                write_reg(hlsu_pkg::CFG_IS_FRAMEWISE, v);
                case (p % 4)
                    0: v = '0;
                    1: v = hlsu_pkg::CFG_DATA_W'(hlsu_pkg::MAX_LENGTH);
                    2: v = hlsu_pkg::CFG_DATA_W'($urandom_range(1, 64));
                    default: v = hlsu_pkg::CFG_DATA_W'($urandom_range(0, hlsu_pkg::MAX_LENGTH));
                endcase
                write_reg(hlsu_pkg::CFG_LENGTH_THRESHOLD, v);
                case (p % 3)
                    0: v = hlsu_pkg::CFG_DATA_W'(32'h8000_0000);
                    1: v = '0;
                    default: v = hlsu_pkg::CFG_DATA_W'(
                        32'(-32'sd1 * $signed(32'($urandom_range(0, 1 << 20)))));
                endcase
                write_reg(hlsu_pkg::CFG_LOG_EPSILON, v);
                case ((p + 1) % 3)
                    0: v = 41'd1 << 40;
                    1: v = '0;
                    default: v = {1'b0, 8'($urandom), 32'($urandom)};
                endcase
                write_reg(hlsu_pkg::CFG_HALF_INV_MEAN_SQ, v);
            end
            // Random words: mostly queries against loaded states, some fresh loads.
            for (int n = 0; n < 36; n++) begin
                if ($urandom_range(0, 9) < 3)
                    add_load(hlsu_pkg::STATE_W'($urandom),
                             hlsu_pkg::LAMBDA_W'($urandom_range(0, 1 << 28)),
                             hlsu_pkg::ROUND_W'($urandom_range(0, hlsu_pkg::MAX_LENGTH)),
                             $urandom,
                             hlsu_pkg::RESCALE_W'({$urandom, $urandom}));
                else
                    add_query(hlsu_pkg::LEN_W'(pick_length()));
            end
        end
        wait_idle();
        if (errors == 0) begin
            $display("hmm_length_score_unit_tb: clean");
        end else begin
            $display("hmm_length_score_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ===== hmm_length_score_unit.f =====
src/hlsu_pkg.sv
src/hmm_length_score_unit.sv
src/hlsu_checker.sv
dv/hmm_length_score_unit_tb.sv
